### hdl/lmcs_pkg.sv
`default_nettype none

package lmcs_pkg;

  // matrix geometry
  localparam int NUM_COLS = 8;
  localparam int NUM_ROWS = 8;
  localparam int COL_W    = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

  // field widths fixed by the port list
  localparam int CMD_W    = 2;
  localparam int PIX_W    = 3;
  localparam int CMP_W    = 16;
  localparam int OUT_W    = 8;
  localparam int IDX_W    = 3;

  localparam logic [CMP_W-1:0] COMPARE_RESET = 16'd400;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } lmcs_cmd_t;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } lmcs_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic tick;
    logic pixel;
    logic clear;
  } lmcs_ctl_t;

endpackage

`default_nettype wire

### hdl/led_matrix_column_scanner.sv
// 8x8 led matrix column scanner
// input channel in_valid/in_ready carries one item per transfer: cmd selects
//   a timer tick, a single pixel write (pixel_col, pixel_row, pixel_on) or a
//   whole-frame clear; cmd 3 changes nothing but still gives a result
// output channel out_valid/out_ready carries one result per item:
//   col_enable (one-hot), row_drive (active low), scan_index, advanced
// latency: a result is valid the cycle after its item transfers
// throughput: one item per clock; the single output register is refilled in
//   the same cycle it is taken, so in_ready follows out_ready when it is full
// compare_value is written through cfg_wr_en/cfg_wr_data, no wait, and takes
//   effect on the next tick; write it only while no result is pending
// reset (rst, synchronous): frame cleared, scan at column 0, tick count 0,
//   compare 400, outputs dark until the first compare match
// receiver stall: with a result held, in_ready drops and nothing is lost;
//   the frame store and timer update only on accepted items
`default_nettype none

module led_matrix_column_scanner (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // item channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [lmcs_pkg::CMD_W-1:0] cmd,
  input  wire logic [lmcs_pkg::PIX_W-1:0] pixel_col,
  input  wire logic [lmcs_pkg::PIX_W-1:0] pixel_row,
  input  wire logic                       pixel_on,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [lmcs_pkg::OUT_W-1:0]      col_enable,
  output logic [lmcs_pkg::OUT_W-1:0]      row_drive,
  output logic [lmcs_pkg::IDX_W-1:0]      scan_index,
  output logic                            advanced,
  // compare register write
  input  wire logic                       cfg_wr_en,
  input  wire logic [lmcs_pkg::CMP_W-1:0] cfg_wr_data
);
  import lmcs_pkg::*;

  // decoded command for the accepted item
  lmcs_ctl_t ctl;

  // handshake and output register occupancy
  lmcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // frame store, tick timer, scan position and result register
  lmcs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .pixel_on    (pixel_on),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .col_enable  (col_enable),
    .row_drive   (row_drive),
    .scan_index  (scan_index),
    .advanced    (advanced)
  );

endmodule

`default_nettype wire

### hdl/lmcs_ctrl.sv
`default_nettype none

module lmcs_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [lmcs_pkg::CMD_W-1:0] cmd,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output lmcs_pkg::lmcs_ctl_t             ctl
);
  import lmcs_pkg::*;

  lmcs_state_t state;
  lmcs_state_t state_next;
  logic        in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_EMPTY: begin
        if (in_fire) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (out_ready && !in_fire) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  // outputs
  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_EMPTY: begin
        in_ready = 1'b1;
      end
      ST_FULL: begin
        in_ready  = out_ready;
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    if (in_fire) begin
      ctl.load = 1'b1;
      unique case (lmcs_cmd_t'(cmd))
        CMD_TICK:  ctl.tick  = 1'b1;
        CMD_PIXEL: ctl.pixel = 1'b1;
        CMD_CLEAR: ctl.clear = 1'b1;
        default:   ctl.load  = 1'b1;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fire_fills: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid) else $error("accepted item left no result");
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("empty output stage refused input");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.tick, ctl.pixel, ctl.clear})) else $error("several commands at once");
`endif

endmodule

`default_nettype wire

### hdl/lmcs_datapath.sv
`default_nettype none

module lmcs_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lmcs_pkg::lmcs_ctl_t        ctl,
  input  wire logic [lmcs_pkg::PIX_W-1:0] pixel_col,
  input  wire logic [lmcs_pkg::PIX_W-1:0] pixel_row,
  input  wire logic                       pixel_on,
  input  wire logic                       cfg_wr_en,
  input  wire logic [lmcs_pkg::CMP_W-1:0] cfg_wr_data,
  output logic [lmcs_pkg::OUT_W-1:0]      col_enable,
  output logic [lmcs_pkg::OUT_W-1:0]      row_drive,
  output logic [lmcs_pkg::IDX_W-1:0]      scan_index,
  output logic                            advanced
);
  import lmcs_pkg::*;

  logic [NUM_ROWS-1:0] frame_store [NUM_COLS];
  logic [COL_W-1:0]    scan_column;
  logic [COL_W-1:0]    scan_column_next;
  logic [CMP_W-1:0]    tick_count;
  logic [CMP_W-1:0]    compare_value;
  logic                scan_started;
  logic                scan_started_next;
  logic [NUM_ROWS-1:0] latched_rows;
  logic [NUM_ROWS-1:0] latched_rows_next;
  logic                hit;
  logic                pix_in_range;
  logic [COL_W-1:0]    wr_col;
  logic [15:0]         rows_wide;
  logic [15:0]         cols_wide;

  assign hit          = ctl.tick && (tick_count == compare_value);
  assign pix_in_range = (32'(pixel_col) < NUM_COLS) && (32'(pixel_row) < NUM_ROWS);
  assign wr_col       = COL_W'(pixel_col);

  always_comb begin
    scan_column_next  = scan_column;
    scan_started_next = scan_started;
    latched_rows_next = latched_rows;
    if (hit) begin
      if (32'(scan_column) == NUM_COLS - 1) begin
        scan_column_next = '0;
      end else begin
        scan_column_next = scan_column + COL_W'(1);
      end
      // frame is not changed by a tick, so the stored row is current
      latched_rows_next = ~frame_store[scan_column_next];
      scan_started_next = 1'b1;
    end
    rows_wide = '1;
    rows_wide[NUM_ROWS-1:0] = latched_rows_next;
    cols_wide = 16'(1) << scan_column_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_value <= COMPARE_RESET;
    end else if (cfg_wr_en) begin
      compare_value <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COLS; i++) frame_store[i] <= '0;
      scan_column  <= '0;
      tick_count   <= '0;
      scan_started <= 1'b0;
      latched_rows <= '1;
    end else begin
      if (ctl.clear) begin
        for (int i = 0; i < NUM_COLS; i++) frame_store[i] <= '0;
      end else if (ctl.pixel && pix_in_range) begin
        frame_store[wr_col][pixel_row] <= pixel_on;
      end
      if (ctl.tick) begin
        tick_count <= hit ? '0 : tick_count + CMP_W'(1);
      end
      scan_column  <= scan_column_next;
      scan_started <= scan_started_next;
      latched_rows <= latched_rows_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      col_enable <= scan_started_next ? cols_wide[OUT_W-1:0] : '0;
      row_drive  <= scan_started_next ? rows_wide[OUT_W-1:0] : '1;
      scan_index <= IDX_W'(scan_column_next);
      advanced   <= hit;
    end
  end

`ifndef SYNTHESIS
  a_hit_clears: assert property (@(posedge clk) disable iff (rst)
    hit |=> (tick_count == '0) && advanced && scan_started)
    else $error("compare match did not restart the count");
  a_col_matches: assert property (@(posedge clk) disable iff (rst)
    $past(ctl.load) && scan_started |-> col_enable == OUT_W'(16'(1) << scan_index))
    else $error("column enable disagrees with scan index");
  a_dark_before: assert property (@(posedge clk) disable iff (rst)
    $past(ctl.load) && !scan_started |-> (col_enable == '0) && (row_drive == '1))
    else $error("outputs lit before first advance");
`endif

endmodule

`default_nettype wire

### tb/sv/led_matrix_column_scanner_test.sv
`default_nettype none

module led_matrix_column_scanner_test;
  import lmcs_pkg::*;

  // longest run of cycles with no transfer on either channel before giving up
  localparam int STALL_LIMIT = 2000;

  // one result item as seen on the output channel
  typedef struct packed {
    logic [OUT_W-1:0] col_enable;
    logic [OUT_W-1:0] row_drive;
    logic [IDX_W-1:0] scan_index;
    logic             advanced;
  } scan_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] cmd = CMD_TICK;
  logic [PIX_W-1:0] pixel_col = '0;
  logic [PIX_W-1:0] pixel_row = '0;
  logic             pixel_on = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OUT_W-1:0] col_enable;
  logic [OUT_W-1:0] row_drive;
  logic [IDX_W-1:0] scan_index;
  logic             advanced;
  logic             cfg_wr_en = 1'b0;
  logic [CMP_W-1:0] cfg_wr_data = '0;

  // predicted scanner state, mirrors the block from reset onward
  logic [NUM_ROWS-1:0] frame_model [NUM_COLS] = '{default: '0};
  logic [COL_W-1:0]    col_model = '0;
  logic [CMP_W-1:0]    count_model = '0;
  logic [CMP_W-1:0]    compare_model = COMPARE_RESET;
  logic                started_model = 1'b0;
  logic [OUT_W-1:0]    rows_model = '1;

  // results predicted for accepted items, oldest first
  scan_result_t pending_scans [$];

  // quiet turns off input gaps and output stalls
  bit quiet = 1'b0;
  bit last_advance;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int advances_seen = 0;
  int compare_writes = 0;
  int stall_cycles = 0;

  led_matrix_column_scanner dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .pixel_on    (pixel_on),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .col_enable  (col_enable),
    .row_drive   (row_drive),
    .scan_index  (scan_index),
    .advanced    (advanced),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // expected outputs for one item, updating the predicted state
  function automatic scan_result_t predict_scan(lmcs_cmd_t op, logic [PIX_W-1:0] col,
                                                logic [PIX_W-1:0] row, logic on);
    scan_result_t res;
    res.advanced = 1'b0;
    case (op)
      CMD_TICK: begin
        // clear-on-compare: the matching tick resets the count and steps the scan
        if (count_model == compare_model) begin
          count_model = '0;
          col_model = COL_W'((int'(col_model) + 1) % NUM_COLS);
          rows_model = '1;
          rows_model[NUM_ROWS-1:0] = ~frame_model[col_model];
          started_model = 1'b1;
          res.advanced = 1'b1;
        end else begin
          count_model = count_model + 1'b1;
        end
      end
      CMD_PIXEL: begin
        // writes outside the matrix are dropped
        if (int'(col) < NUM_COLS && int'(row) < NUM_ROWS)
          frame_model[col][row] = on;
      end
      CMD_CLEAR: begin
        foreach (frame_model[i]) frame_model[i] = '0;
      end
      default: ;
    endcase
    // dark until the first advance
    res.col_enable = '0;
    res.col_enable[col_model] = started_model;
    res.row_drive = started_model ? rows_model : '1;
    res.scan_index = IDX_W'(col_model);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", results_checked, msg);
    mismatches++;
  endtask

  // one item transfer; returns at the edge where it was accepted, valid left high
  task automatic drive_item(lmcs_cmd_t op, logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                            logic on);
    scan_result_t want;
    if (!quiet && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    pixel_col <= col;
    pixel_row <= row;
    pixel_on  <= on;
    do @(posedge clk); while (in_ready !== 1'b1);
    want = predict_scan(op, col, row, on);
    last_advance = want.advanced;
    pending_scans.push_back(want);
    items_sent++;
  endtask

  // let the block drain so it is idle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_compare(logic [CMP_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    compare_model = value;
    compare_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic tick_until_advance();
    do drive_item(CMD_TICK, PIX_W'($urandom), PIX_W'($urandom), 1'($urandom));
    while (!last_advance);
  endtask

  // move the compare onto the running count and tick once, so the count restarts at 0
  task automatic sync_count();
    write_compare(count_model);
    drive_item(CMD_TICK, PIX_W'($urandom), PIX_W'($urandom), 1'($urandom));
  endtask

  // ticks, writes and a no-op at reset compare: nothing lights
  task automatic test_dark_until_first_advance();
    drive_item(CMD_PIXEL, 3'd1, 3'd0, 1'b1);
    drive_item(CMD_PIXEL, 3'd1, 3'd7, 1'b1);
    drive_item(CMD_TICK, 3'd0, 3'd0, 1'b0);
    drive_item(CMD_NONE, 3'd7, 3'd7, 1'b1);
    drive_item(CMD_TICK, 3'd7, 3'd7, 1'b1);
  endtask

  // compare 0: every tick steps the scan, walk all columns and two frame corners
  task automatic test_fast_scan_edges();
    sync_count();                             // first advance shows column 1
    write_compare('0);
    drive_item(CMD_TICK, 3'd0, 3'd0, 1'b0);
    drive_item(CMD_PIXEL, 3'd0, 3'd7, 1'b1);  // store only, latch unchanged
    drive_item(CMD_PIXEL, 3'd7, 3'd0, 1'b1);
    drive_item(CMD_PIXEL, 3'd1, 3'd0, 1'b0);
    drive_item(CMD_NONE, 3'd0, 3'd0, 1'b0);
    repeat (7) drive_item(CMD_TICK, 3'd0, 3'd0, 1'b0);  // wrap back around
    drive_item(CMD_CLEAR, 3'd7, 3'd7, 1'b1);
    drive_item(CMD_TICK, 3'd7, 3'd7, 1'b1);
    drive_item(CMD_PIXEL, 3'd2, 3'd7, 1'b1);
    drive_item(CMD_TICK, 3'd0, 3'd0, 1'b0);
    write_compare(CMP_W'(1));
    repeat (2) tick_until_advance();
  endtask

  // compare at its maximum: a long run of ticks with no match, no idling at all
  task automatic test_compare_max();
    write_compare('1);
    quiet = 1'b1;
    repeat (60) drive_item(CMD_TICK, 3'd0, 3'd0, 1'b0);
    quiet = 1'b0;
  endtask

  // compare lowered under the running count: no match until the count wraps
  task automatic test_compare_below_count();
    write_compare(CMP_W'(100));
    repeat (40) drive_item(CMD_TICK, 3'd0, 3'd0, 1'b0);
    write_compare(CMP_W'(5));
    quiet = 1'b1;
    repeat (60) drive_item(CMD_TICK, 3'd0, 3'd0, 1'b0);
    quiet = 1'b0;
  endtask

  // random mix of ticks and frame edits over several compare settings
  task automatic test_random_scan();
    int unsigned pick;
    for (int phase = 0; phase < 6; phase++) begin
      sync_count();
      case (phase)
        0: write_compare('0);
        1: write_compare(CMP_W'(1));
        2: write_compare(CMP_W'($urandom_range(2, 15)));
        3: write_compare(CMP_W'(7));
        4: write_compare(CMP_W'($urandom_range(0, 3)));
        default: write_compare(CMP_W'($urandom_range(0, 31)));
      endcase
      repeat (120) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)
          drive_item(CMD_TICK, PIX_W'($urandom), PIX_W'($urandom), 1'($urandom));
        else if (pick < 88)
          drive_item(CMD_PIXEL, PIX_W'($urandom), PIX_W'($urandom), 1'($urandom));
        else if (pick < 94)
          drive_item(CMD_CLEAR, PIX_W'($urandom), PIX_W'($urandom), 1'($urandom));
        else
          drive_item(CMD_NONE, PIX_W'($urandom), PIX_W'($urandom), 1'($urandom));
      end
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_scans.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_scans.pop_front();
        if (col_enable !== want.col_enable)
          report_mismatch($sformatf("col_enable %h, want %h", col_enable, want.col_enable));
        if (row_drive !== want.row_drive)
          report_mismatch($sformatf("row_drive %h, want %h", row_drive, want.row_drive));
        if (scan_index !== want.scan_index)
          report_mismatch($sformatf("scan_index %0d, want %0d", scan_index, want.scan_index));
        if (advanced !== want.advanced)
          report_mismatch($sformatf("advanced %b, want %b", advanced, want.advanced));
        if (want.advanced) advances_seen++;
      end
      results_checked++;
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("watchdog: %0d cycles without a transfer", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_dark_until_first_advance();
    test_fast_scan_edges();
    test_compare_max();
    test_compare_below_count();
    test_random_scan();

    // all items in, wait for the last results
    drain();
    if (pending_scans.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_scans.size()));

    $display("run covered %0d items and %0d checked results over %0d compare settings",
             items_sent, results_checked, compare_writes);
    $display("%0d column advances seen, %0d mismatches", advances_seen, mismatches);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
